// ----- rtl/ssa_pkg.sv -----
// Shared constants, types and codes of the segment sum accumulator.
package ssa_pkg;

  localparam int SEGMENTS = 256;
  localparam int COLUMNS  = 16;
  localparam int BATCHES  = 4;
  localparam int DEPTH    = BATCHES * SEGMENTS * COLUMNS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  localparam logic REQ_ACC = 1'b0;
  localparam logic REQ_RD  = 1'b1;

  typedef struct packed {
    logic              req;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       value;
  } ssa_item_t;

  typedef struct packed {
    logic clearing;
    logic take;
  } ssa_stat_t;

  typedef struct packed {
    logic align;
    logic norm;
  } ssa_addctl_t;

endpackage

// ----- rtl/segment_sum_accumulator_unit.sv -----
// Top level of the segment sum accumulator (scatter-add engine).
//
// Input queue: drive in_req_type, in_batch, in_segment, in_column and in_value with
// in_push high; the transfer happens at a clock edge where in_full is low. An
// accumulate adds in_value (binary32, round to nearest even) into the addressed
// entry; a read returns the entry's sum on out_sum and clears the entry to +0.
// Result slot: while out_empty is low, out_sum holds the one pending result; it is
// transferred at an edge with out_pop high. Accumulates produce no result.
// Items are executed one at a time: an accumulate goes through table read, align and
// add, normalise, then round and write back; a read through table read and clear;
// an item outside the table is finished without a table access; the single table
// memory port pair sets this. A four-entry queue in front lets the source keep
// pushing meanwhile. After reset the table's 16384 entries are cleared one entry
// per cycle, with in_full held high. If the receiver stalls, the result waits and
// a further read waits behind it, and so do the items queued after that read;
// accumulates ahead of it still proceed.
module segment_sum_accumulator_unit
  import ssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [1:0]  in_batch,
  input  logic [7:0]  in_segment,
  input  logic [3:0]  in_column,
  input  logic [31:0] in_value,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [31:0] out_sum
);

  ssa_stat_t stat;
  logic      q_valid;
  ssa_item_t q_item;

  ssa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_req_type (in_req_type),
    .in_batch    (in_batch),
    .in_segment  (in_segment),
    .in_column   (in_column),
    .in_value    (in_value),
    .stat        (stat),
    .q_valid     (q_valid),
    .q_item      (q_item)
  );

  ssa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .stat      (stat),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_sum   (out_sum)
  );

endmodule

// ----- rtl/ssa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ssa_front.sv -----
// Front end: decodes the entry address of each item and queues it for the back end.
module ssa_front
  import ssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [1:0]  in_batch,
  input  logic [7:0]  in_segment,
  input  logic [3:0]  in_column,
  input  logic [31:0] in_value,
  input  ssa_stat_t   stat,
  output logic        q_valid,
  output ssa_item_t   q_item
);

  ssa_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic [31:0]       idx;
  logic              hit, push;
  ssa_item_t         item;

  always_comb begin
    idx = (32'(in_batch) * 32'(SEGMENTS) + 32'(in_segment)) * 32'(COLUMNS) + 32'(in_column);
    hit = (32'(in_batch) < 32'(BATCHES)) && (32'(in_segment) < 32'(SEGMENTS)) &&
          (32'(in_column) < 32'(COLUMNS));
    item.req   = in_req_type;
    item.hit   = hit;
    item.addr  = idx[ADDR_W-1:0];
    item.value = in_value;
  end

  assign in_full = (cnt_r == (QPTR_W+1)'(QDEPTH)) || stat.clearing;
  assign push    = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = stat.take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(stat.take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ----- rtl/ssa_fpadd.sv -----
// Three-step binary32 adder: align and add, normalise, then round.
module ssa_fpadd
  import ssa_pkg::*;
(
  input  logic        clk,
  input  ssa_addctl_t ctl,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);

  // Align and add.
  logic [7:0]  ea, eb, xa, xb, d;
  logic [22:0] ma, mb;
  logic        swap, sgn_a, sgn_b, sp, same;
  logic [31:0] spv, big, sml;
  logic [26:0] sa, sb, sbs, mask;
  logic [27:0] s;

  logic        sp_r, sgn_r;
  logic [31:0] spv_r;
  logic [7:0]  x_r;
  logic [27:0] s_r;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    ma = a[22:0];
    mb = b[22:0];
    sp  = 1'b0;
    spv = QNAN_BITS;
    if ((ea == 8'hFF && ma != '0) || (eb == 8'hFF && mb != '0)) begin
      sp = 1'b1;
    end else if (ea == 8'hFF) begin
      sp = 1'b1;
      if (!(eb == 8'hFF && a[31] != b[31])) spv = a;
    end else if (eb == 8'hFF) begin
      sp  = 1'b1;
      spv = b;
    end
    swap  = b[30:0] > a[30:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    sgn_a = big[31];
    sgn_b = sml[31];
    same  = (sgn_a == sgn_b);
    xa = (big[30:23] == '0) ? 8'd1 : big[30:23];
    xb = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    sa = {(big[30:23] != '0), big[22:0], 3'b000};
    sb = {(sml[30:23] != '0), sml[22:0], 3'b000};
    d  = xa - xb;
    mask = ~(27'h7FF_FFFF << d);
    if (d >= 8'd31) begin
      sbs = {26'b0, (sb != '0)};
    end else begin
      sbs = (sb >> d) | {26'b0, ((sb & mask) != '0)};
    end
    s = same ? ({1'b0, sa} + {1'b0, sbs}) : ({1'b0, sa} - {1'b0, sbs});
    if (!sp && s == '0) begin
      sp  = 1'b1;
      spv = same ? {sgn_a, 31'b0} : 32'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.align) begin
      sp_r  <= sp;
      spv_r <= spv;
      sgn_r <= sgn_a;
      x_r   <= xa;
      s_r   <= s;
    end
  end

  // Normalise.
  logic [4:0]  msb, lz, sh;
  logic [7:0]  maxsh;
  logic [26:0] n;
  logic [8:0]  xn;
  logic [26:0] n_r;
  logic [8:0]  xn_r;
  logic        sp2_r, sgn2_r;
  logic [31:0] spv2_r;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 27; i++) begin
      if (s_r[i]) msb = 5'(i);
    end
    lz    = 5'd26 - msb;
    maxsh = x_r - 8'd1;
    sh    = ({3'b0, lz} > maxsh) ? maxsh[4:0] : lz;
    if (s_r[27]) begin
      n  = {s_r[27:2], s_r[1] | s_r[0]};
      xn = {1'b0, x_r} + 9'd1;
    end else begin
      n  = s_r[26:0] << sh;
      xn = {1'b0, x_r} - {4'b0, sh};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.norm) begin
      n_r    <= n;
      xn_r   <= xn;
      sp2_r  <= sp_r;
      spv2_r <= spv_r;
      sgn2_r <= sgn_r;
    end
  end

  // Round to nearest even and pack.
  logic [24:0] m;
  logic [8:0]  xr;
  logic        inc;

  always_comb begin
    inc = (n_r[2:0] > 3'd4) || (n_r[2:0] == 3'd4 && n_r[3]);
    m   = {1'b0, n_r[26:3]} + 25'(inc);
    xr  = xn_r;
    if (m[24]) begin
      m  = m >> 1;
      xr = xn_r + 9'd1;
    end
    if (sp2_r) begin
      res = spv2_r;
    end else if (xr >= 9'd255) begin
      res = {sgn2_r, 31'h7F80_0000};
    end else if (!m[23]) begin
      res = {sgn2_r, 8'b0, m[22:0]};
    end else begin
      res = {sgn2_r, xr[7:0], m[22:0]};
    end
  end

endmodule

// ----- rtl/ssa_back.sv -----
// Back end: clears the sum table after reset, then executes queued items one at a time.
module ssa_back
  import ssa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  ssa_item_t   q_item,
  output ssa_stat_t   stat,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [31:0] out_sum
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  ssa_item_t         cur_r;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_sum_r, out_sum_nxt;
  logic              take, slot_free, we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata, rdata, add_res;
  ssa_addctl_t       actl;

  ssa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (q_item.addr),
    .rdata (rdata)
  );

  ssa_fpadd u_add (
    .clk (clk),
    .ctl (actl),
    .a   (rdata),
    .b   (cur_r.value),
    .res (add_res)
  );

  assign slot_free = !out_valid_r || out_pop;
  assign take      = (state_r == S_IDLE) && q_valid &&
                     (q_item.req == REQ_ACC || slot_free);
  assign stat.take     = take;
  assign stat.clearing = (state_r == S_CLR);
  assign out_empty     = !out_valid_r;
  assign out_sum       = out_sum_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_sum_nxt   = out_sum_r;
    we            = 1'b0;
    waddr         = cur_r.addr;
    wdata         = '0;
    actl.align    = 1'b0;
    actl.norm     = 1'b0;
    unique case (state_r)
      S_CLR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          if (q_item.hit) begin
            state_nxt = S_RD;
          end else if (q_item.req == REQ_RD) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = '0;
          end
        end
      end
      S_RD: begin
        if (cur_r.req == REQ_RD) begin
          // Read-and-clear: hand out the sum and zero the entry.
          we            = 1'b1;
          out_valid_nxt = 1'b1;
          out_sum_nxt   = rdata;
          state_nxt     = S_IDLE;
        end else begin
          actl.align = 1'b1;
          state_nxt  = S_NORM;
        end
      end
      S_NORM: begin
        actl.norm = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        we        = 1'b1;
        wdata     = add_res;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
    if (take) cur_r <= q_item;
  end

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !take) else $error("item taken during table clear");

  a_norm_then_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM) |=> (state_r == S_RND)) else $error("adder sequence broken");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && cur_r.req == REQ_RD) |=> out_valid_r)
    else $error("read finished without a result");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop && state_r == S_RD && cur_r.req == REQ_RD) |-> 1'b0)
    else $error("pending result overwritten");

endmodule

// ----- verif/tb_segment_sum_accumulator_unit.sv -----
// Self-checking testbench for the segment sum accumulator: scatter-add with read-and-clear.
`timescale 1ns / 1ps

module tb_segment_sum_accumulator_unit;
  import ssa_pkg::*;

  typedef struct packed {
    logic        req;
    logic [1:0]  batch;
    logic [7:0]  segment;
    logic [3:0]  column;
    logic [31:0] value;
  } sum_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_req_type = REQ_ACC;
  logic [1:0]  in_batch = '0;
  logic [7:0]  in_segment = '0;
  logic [3:0]  in_column = '0;
  logic [31:0] in_value = '0;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [31:0] out_sum;

  segment_sum_accumulator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_req_type(in_req_type),
    .in_batch(in_batch), .in_segment(in_segment), .in_column(in_column),
    .in_value(in_value),
    .out_pop(out_pop), .out_empty(out_empty), .out_sum(out_sum)
  );

  always #6 clk = ~clk;

  sum_req_t    pending_reqs[$];
  logic [31:0] expected_sums[$];
  logic [31:0] model_table[DEPTH];
  int          mismatches = 0;
  int          quiet_tail = 0;   // no idling once set
  int          hold_pop = 0;     // long receiver hold-off, in cycles
  logic        drain_wait = 1'b0; // sender pauses until all results are in
  int          send_gap = 0;
  int          pop_gap = 0;
  bit          accepted_all = 1'b0;

  function automatic logic [31:0] fp32_sum(logic [31:0] a, logic [31:0] b);
    logic [7:0]  ea, eb;
    logic [22:0] ma, mb;
    logic        sa_s, sb_s;
    logic [31:0] t, fa, fb, s, sticky, lsb, rb;
    int          xa, xb, x, d;
    ea = a[30:23]; eb = b[30:23]; ma = a[22:0]; mb = b[22:0];
    sa_s = a[31]; sb_s = b[31];
    if ((ea == 8'hFF && ma != 0) || (eb == 8'hFF && mb != 0)) return QNAN_BITS;
    if (ea == 8'hFF) begin
      if (eb == 8'hFF && sa_s != sb_s) return QNAN_BITS;
      return a;
    end
    if (eb == 8'hFF) return b;
    if (b[30:0] > a[30:0]) begin
      t = a; a = b; b = t;
      ea = a[30:23]; eb = b[30:23]; ma = a[22:0]; mb = b[22:0];
      sa_s = a[31]; sb_s = b[31];
    end
    xa = (ea == 0) ? 1 : int'(ea);
    xb = (eb == 0) ? 1 : int'(eb);
    fa = {5'd0, (ea != 0), ma, 3'd0};
    fb = {5'd0, (eb != 0), mb, 3'd0};
    d = xa - xb;
    if (d >= 31) fb = {31'd0, (fb != 0)};
    else if (d > 0) begin
      sticky = {31'd0, ((fb & ((32'd1 << d) - 32'd1)) != 0)};
      fb = (fb >> d) | sticky;
    end
    s = (sa_s == sb_s) ? fa + fb : fa - fb;
    if (s == 0) return (sa_s == sb_s) ? {sa_s, 31'd0} : 32'd0;
    x = xa;
    if (s >= (32'd1 << 27)) begin
      s = (s >> 1) | (s & 32'd1);
      x++;
    end else begin
      while (s < (32'd1 << 26) && x > 1) begin
        s = s << 1;
        x--;
      end
    end
    lsb = (s >> 3) & 32'd1;
    rb = s & 32'd7;
    s = s >> 3;
    if (rb > 4 || (rb == 4 && lsb != 0)) s++;
    if (s >= (32'd1 << 24)) begin
      s = s >> 1;
      x++;
    end
    if (x >= 255) return {sa_s, 31'h7F80_0000};
    if (s < (32'd1 << 23)) return {sa_s, s[30:0]};
    return {sa_s, x[7:0], s[22:0]};
  endfunction

  // Applies one accepted request to the model table and records any read result.
  task automatic apply_request(sum_req_t r);
    int idx;
    idx = (r.batch * SEGMENTS + r.segment) * COLUMNS + r.column;
    if (r.req == REQ_ACC) begin
      model_table[idx] = fp32_sum(model_table[idx], r.value);
    end else begin
      expected_sums.push_back(model_table[idx]);
      model_table[idx] = 32'd0;
    end
  endtask

  // Long receiver hold-off, counted down on its own.
  always @(negedge clk) begin
    if (hold_pop > 0) hold_pop <= hold_pop - 1;
  end

  // Driver: offers the head of the pending queue and drives out_pop, inputs changed at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (drain_wait && expected_sums.size() == 0)
        drain_wait <= 1'b0;
      if (send_gap > 0) send_gap <= send_gap - 1;
      if (pending_reqs.size() > 0 && !drain_wait && send_gap == 0 &&
          !(quiet_tail == 0 && $urandom_range(0, 9) == 0)) begin
        in_push     <= 1'b1;
        in_req_type <= pending_reqs[0].req;
        in_batch    <= pending_reqs[0].batch;
        in_segment  <= pending_reqs[0].segment;
        in_column   <= pending_reqs[0].column;
        in_value    <= pending_reqs[0].value;
      end else begin
        in_push <= 1'b0;
        if (quiet_tail == 0 && send_gap == 0 && pending_reqs.size() > 0)
          send_gap <= $urandom_range(0, 4);
      end
      if (hold_pop > 0) begin
        out_pop  <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        out_pop <= 1'b0;
      end else if (quiet_tail == 0 && $urandom_range(0, 7) == 0) begin
        pop_gap <= $urandom_range(0, 4);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Predictor and checker, both evaluated at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        apply_request('{in_req_type, in_batch, in_segment, in_column, in_value});
        void'(pending_reqs.pop_front());
      end
      if (out_pop && !out_empty) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: sum=%h", out_sum);
        end else begin
          if (out_sum !== expected_sums[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sum mismatch: expected %h actual %h", expected_sums[0], out_sum);
          end
          void'(expected_sums.pop_front());
        end
      end
    end
  end

  function automatic sum_req_t make_req(logic req, logic [1:0] b, logic [7:0] s,
                                        logic [3:0] c, logic [31:0] v);
    make_req = '{req, b, s, c, v};
  endfunction

  function automatic logic [31:0] rand_fp32();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:23] = 8'hFE;
      3: v = {v[31], 31'd0};
      default: v[30:23] = 8'd120 + 8'($urandom_range(0, 16));
    endcase
    return v;
  endfunction

  initial begin
    logic [1:0] b;
    logic [7:0] s;
    logic [3:0] c;
    int         n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) model_table[i] = 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of address, signed zeros, cancellation, NaN, infinities, overflow.
    pending_reqs.push_back(make_req(REQ_RD, 2'd3, 8'd255, 4'd15, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd3, 8'd255, 4'd15, 32'h7F7F_FFFF));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd3, 8'd255, 4'd15, 32'h7F7F_FFFF));
    pending_reqs.push_back(make_req(REQ_RD, 2'd3, 8'd255, 4'd15, 32'd0));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd0, 8'd0, 4'd0, 32'h8000_0000));
    pending_reqs.push_back(make_req(REQ_RD, 2'd0, 8'd0, 4'd0, 32'd0));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd1, 8'd1, 4'd1, 32'h3F80_0000));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd1, 8'd1, 4'd1, 32'hBF80_0000));
    pending_reqs.push_back(make_req(REQ_RD, 2'd1, 8'd1, 4'd1, 32'd0));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd2, 8'd7, 4'd3, 32'h7F80_0000));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd2, 8'd7, 4'd3, 32'hFF80_0000));
    pending_reqs.push_back(make_req(REQ_RD, 2'd2, 8'd7, 4'd3, 32'd0));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd2, 8'd8, 4'd3, 32'hFFC1_2345));
    pending_reqs.push_back(make_req(REQ_RD, 2'd2, 8'd8, 4'd3, 32'd0));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd0, 8'd9, 4'd2, 32'h0000_0001));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd0, 8'd9, 4'd2, 32'h807F_FFFF));
    pending_reqs.push_back(make_req(REQ_RD, 2'd0, 8'd9, 4'd2, 32'd0));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd1, 8'd5, 4'd5, 32'h4B80_0000));
    pending_reqs.push_back(make_req(REQ_ACC, 2'd1, 8'd5, 4'd5, 32'h3F80_0001));
    pending_reqs.push_back(make_req(REQ_RD, 2'd1, 8'd5, 4'd5, 32'd0));
    wait (pending_reqs.size() == 0);

    // The receiver holds off while reads keep arriving, so the block fills up.
    hold_pop = 80;
    for (int i = 0; i < 40; i++)
      pending_reqs.push_back(make_req(REQ_RD, 2'($urandom), 8'($urandom), 4'($urandom),
                                      $urandom));
    wait (pending_reqs.size() == 0);
    drain_wait = 1'b1;
    wait (!drain_wait);

    // Random jobs on a small working set: up to five accumulates per entry, then a read.
    while (pending_reqs.size() + 100 < 800 && n < 740) begin
      b = 2'($urandom); s = 8'($urandom_range(0, 3)); c = 4'($urandom);
      if ($urandom_range(0, 9) == 0) s = 8'($urandom);
      for (int k = $urandom_range(0, 5); k > 0; k--) begin
        pending_reqs.push_back(make_req(REQ_ACC, b, s, c, rand_fp32()));
        n++;
      end
      pending_reqs.push_back(make_req(REQ_RD, b, s, c, $urandom));
      n++;
      if (n > 600) quiet_tail = 1;
      wait (pending_reqs.size() < 20);
    end
    wait (pending_reqs.size() == 0);
    accepted_all = 1'b1;
    wait (expected_sums.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("segment_sum_accumulator_unit regression: pass");
    else
      $display("segment_sum_accumulator_unit regression: fail");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("segment_sum_accumulator_unit regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ssa_pkg.sv
rtl/ssa_ram.sv
rtl/ssa_front.sv
rtl/ssa_fpadd.sv
rtl/ssa_back.sv
rtl/segment_sum_accumulator_unit.sv
verif/tb_segment_sum_accumulator_unit.sv
